@@ src/interval_value_map_macros.svh @@
// assertion helpers for the interval value map
`ifndef INTERVAL_VALUE_MAP_MACROS_SVH
`define INTERVAL_VALUE_MAP_MACROS_SVH

// same-cycle implication
`define IVM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ivm check failed");

// next-cycle implication
`define IVM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ivm check failed");

`endif

@@ src/ivm_pkg.sv @@
`default_nettype none
package ivm_pkg;

	localparam logic [2:0] FUNC_ASSIGN   = 3'd0;
	localparam logic [2:0] FUNC_LOOKUP   = 3'd1;
	localparam logic [2:0] FUNC_NEXT_ANY = 3'd2;
	localparam logic [2:0] FUNC_NEXT_EQ  = 3'd3;
	localparam logic [2:0] FUNC_NEXT_NE  = 3'd4;

	localparam logic signed [33:0] TOP_END = 34'sd2147483648;
	localparam logic signed [33:0] LEN_MAX = 34'sd4294967295;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISP,
		ST_FETCH,
		ST_LEFT,
		ST_NEW,
		ST_RIGHT,
		ST_TAIL,
		ST_FLUSH,
		ST_QCHK,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		PC_LEFT,
		PC_NEW,
		PC_RIGHT
	} piece_sel_t;

	typedef struct packed {
		logic       load;
		logic       emit;
		piece_sel_t sel;
		logic       flush;
		logic       inc_k;
		logic       hit_take;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic is_assign;
		logic is_query;
		logic len_zero;
		logic empty;
		logic lo_lt_s;
		logic hi_gt_e;
		logic new_pend;
		logic last;
		logic hit;
	} sts_t;

endpackage
`default_nettype wire

@@ src/ivm_ctrl.sv @@
`default_nettype none
module ivm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire ivm_pkg::sts_t sts,
	output ivm_pkg::cmd_t      cmd,
	output logic               busy,
	output logic               done
);

	ivm_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ivm_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ivm_pkg::ST_IDLE: if (start) state_nx = ivm_pkg::ST_DISP;
			ivm_pkg::ST_DISP: begin
				priority if (sts.is_assign) begin
					priority if (sts.len_zero) state_nx = ivm_pkg::ST_DONE;
					else if (sts.empty) state_nx = ivm_pkg::ST_TAIL;
					else state_nx = ivm_pkg::ST_FETCH;
				end else if (sts.is_query) begin
					state_nx = sts.empty ? ivm_pkg::ST_DONE : ivm_pkg::ST_FETCH;
				end else begin
					state_nx = ivm_pkg::ST_DONE;
				end
			end
			ivm_pkg::ST_FETCH:
				state_nx = sts.is_assign ? ivm_pkg::ST_LEFT : ivm_pkg::ST_QCHK;
			ivm_pkg::ST_LEFT:  state_nx = ivm_pkg::ST_NEW;
			ivm_pkg::ST_NEW:   state_nx = ivm_pkg::ST_RIGHT;
			ivm_pkg::ST_RIGHT:
				state_nx = sts.last ? ivm_pkg::ST_TAIL : ivm_pkg::ST_FETCH;
			ivm_pkg::ST_TAIL:  state_nx = ivm_pkg::ST_FLUSH;
			ivm_pkg::ST_FLUSH: state_nx = ivm_pkg::ST_DONE;
			ivm_pkg::ST_QCHK: begin
				if (sts.hit || sts.last) state_nx = ivm_pkg::ST_DONE;
				else state_nx = ivm_pkg::ST_FETCH;
			end
			ivm_pkg::ST_DONE:  state_nx = ivm_pkg::ST_IDLE;
			default:           state_nx = ivm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.sel = ivm_pkg::PC_NEW;
		busy = (state_q != ivm_pkg::ST_IDLE);
		done = 1'b0;
		unique case (state_q)
			ivm_pkg::ST_IDLE: cmd.load = start;
			ivm_pkg::ST_LEFT: begin
				cmd.sel = ivm_pkg::PC_LEFT;
				cmd.emit = sts.lo_lt_s;
			end
			ivm_pkg::ST_NEW: begin
				cmd.sel = ivm_pkg::PC_NEW;
				cmd.emit = sts.hi_gt_e && sts.new_pend;
			end
			ivm_pkg::ST_RIGHT: begin
				cmd.sel = ivm_pkg::PC_RIGHT;
				cmd.emit = sts.hi_gt_e;
				cmd.inc_k = 1'b1;
			end
			ivm_pkg::ST_TAIL: begin
				cmd.sel = ivm_pkg::PC_NEW;
				cmd.emit = sts.new_pend;
			end
			ivm_pkg::ST_FLUSH: cmd.flush = 1'b1;
			ivm_pkg::ST_QCHK: begin
				cmd.hit_take = sts.hit;
				cmd.inc_k = !sts.hit;
			end
			ivm_pkg::ST_DONE: begin
				cmd.finish = 1'b1;
				done = 1'b1;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

@@ src/ivm_dpath.sv @@
`default_nettype none
module ivm_dpath #(
	parameter int MAX_INTERVALS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [2:0]         func,
	input  wire logic signed [31:0] position,
	input  wire logic [31:0]        span_length,
	input  wire logic signed [31:0] fill_value,
	input  wire ivm_pkg::cmd_t      cmd,
	output ivm_pkg::sts_t           sts,
	output logic                    found,
	output logic signed [31:0]      out_value,
	output logic signed [31:0]      out_start,
	output logic [31:0]             out_length,
	output logic                    table_full
);

	localparam int IW    = $clog2(MAX_INTERVALS);
	localparam int CW    = $clog2(MAX_INTERVALS + 1);
	localparam int DEPTH = 2 * (1 << IW);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_INTERVALS);

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] len;
		logic [31:0] val;
	} ent_t;

	ent_t mem [DEPTH];
	ent_t rd_q;

	logic [2:0]         func_q;
	logic signed [33:0] s_q, e_q;
	logic [31:0]        len_q;
	logic signed [31:0] val_q;
	logic               new_pend_q;
	logic               bank_q;
	logic [CW-1:0]      count_q, k_q, m_q;
	logic               full_q;
	logic               pv_q;
	logic signed [33:0] plo_q, phi_q;
	logic signed [31:0] pval_q;
	logic               found_q;
	logic signed [31:0] oval_q, ostart_q;
	logic [31:0]        olen_q;

	logic signed [33:0] ent_lo, ent_hi, sum, p_lo, p_hi;
	logic signed [31:0] p_val;
	logic               merge, wr_en, put;
	logic [CW-1:0]      k_next;

	assign ent_lo = {{2{rd_q.start[31]}}, rd_q.start};
	assign ent_hi = ent_lo + $signed({2'b00, rd_q.len});
	assign sum    = {{2{position[31]}}, position} + $signed({2'b00, span_length});
	assign k_next = k_q + 1'b1;

	always_comb begin
		p_val = $signed(rd_q.val);
		unique case (cmd.sel)
			ivm_pkg::PC_LEFT: begin
				p_lo = ent_lo;
				p_hi = (ent_hi < s_q) ? ent_hi : s_q;
			end
			ivm_pkg::PC_RIGHT: begin
				p_lo = (ent_lo > e_q) ? ent_lo : e_q;
				p_hi = ent_hi;
			end
			default: begin
				p_lo  = s_q;
				p_hi  = e_q;
				p_val = val_q;
			end
		endcase
	end

	assign merge = pv_q && (phi_q == p_lo) && (pval_q == p_val)
		&& ((p_hi - plo_q) <= ivm_pkg::LEN_MAX);
	assign put   = pv_q && ((cmd.emit && !merge) || cmd.flush);
	assign wr_en = put && (m_q != MAX_C);

	always_comb begin
		sts.is_assign = (func_q == ivm_pkg::FUNC_ASSIGN);
		sts.is_query  = (func_q == ivm_pkg::FUNC_LOOKUP) || (func_q == ivm_pkg::FUNC_NEXT_ANY)
			|| (func_q == ivm_pkg::FUNC_NEXT_EQ) || (func_q == ivm_pkg::FUNC_NEXT_NE);
		sts.len_zero  = (len_q == '0);
		sts.empty     = (count_q == '0);
		sts.lo_lt_s   = (ent_lo < s_q);
		sts.hi_gt_e   = (ent_hi > e_q);
		sts.new_pend  = new_pend_q;
		sts.last      = (k_next == count_q);
		unique case (func_q)
			ivm_pkg::FUNC_LOOKUP:   sts.hit = (ent_lo <= s_q) && (s_q < ent_hi);
			ivm_pkg::FUNC_NEXT_ANY: sts.hit = (s_q < ent_hi);
			ivm_pkg::FUNC_NEXT_EQ:  sts.hit = (s_q < ent_hi) && ($signed(rd_q.val) == val_q);
			ivm_pkg::FUNC_NEXT_NE:  sts.hit = (s_q < ent_hi) && ($signed(rd_q.val) != val_q);
			default:                sts.hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[{bank_q, k_q[IW-1:0]}];
		if (wr_en) begin
			mem[{!bank_q, m_q[IW-1:0]}] <= '{start: plo_q[31:0],
				len: 32'(phi_q - plo_q), val: pval_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q  <= 1'b0;
			count_q <= '0;
		end else if (cmd.finish && sts.is_assign && !sts.len_zero && !full_q) begin
			bank_q  <= !bank_q;
			count_q <= m_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q     <= func;
			s_q        <= {{2{position[31]}}, position};
			e_q        <= (sum > ivm_pkg::TOP_END) ? ivm_pkg::TOP_END : sum;
			len_q      <= span_length;
			val_q      <= fill_value;
			new_pend_q <= (fill_value != '0);
			k_q        <= '0;
			m_q        <= '0;
			full_q     <= 1'b0;
			pv_q       <= 1'b0;
			found_q    <= 1'b0;
			oval_q     <= '0;
			ostart_q   <= '0;
			olen_q     <= '0;
		end else begin
			if (cmd.inc_k) k_q <= k_next;
			if (cmd.emit && cmd.sel == ivm_pkg::PC_NEW) new_pend_q <= 1'b0;
			if (put) begin
				if (m_q == MAX_C) full_q <= 1'b1;
				else m_q <= m_q + 1'b1;
			end
			if (cmd.emit) begin
				pv_q  <= 1'b1;
				phi_q <= p_hi;
				if (!merge) begin
					plo_q  <= p_lo;
					pval_q <= p_val;
				end
			end else if (cmd.flush) begin
				pv_q <= 1'b0;
			end
			if (cmd.hit_take) begin
				found_q  <= 1'b1;
				oval_q   <= $signed(rd_q.val);
				ostart_q <= $signed(rd_q.start);
				olen_q   <= rd_q.len;
			end
		end
	end

	assign found      = found_q;
	assign out_value  = oval_q;
	assign out_start  = ostart_q;
	assign out_length = olen_q;
	assign table_full = full_q && sts.is_assign;

endmodule
`default_nettype wire

@@ src/interval_value_map.sv @@
// channel   signals                                          handshake
// command   func, position, span_length, fill_value          start & !busy
// result    found, out_value, out_start, out_length, table_full  done, one cycle
//
// Assign: fetch/left/new/right steps per entry, one table read port per step.
// Lookup/search: scan to a hit or the last entry; other codes skip the table.
// Reset empties the table at once; no clearing pass.
// busy stays high from acceptance through the done cycle; results cannot stall.
`default_nettype none
module interval_value_map #(
	parameter int MAX_INTERVALS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         func,
	input  wire logic signed [31:0] position,
	input  wire logic [31:0]        span_length,
	input  wire logic signed [31:0] fill_value,
	output logic                    done,
	output logic                    found,
	output logic signed [31:0]      out_value,
	output logic signed [31:0]      out_start,
	output logic [31:0]             out_length,
	output logic                    table_full
);

	ivm_pkg::cmd_t cmd;
	ivm_pkg::sts_t sts;

	ivm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ivm_dpath #(.MAX_INTERVALS(MAX_INTERVALS)) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.func        (func),
		.position    (position),
		.span_length (span_length),
		.fill_value  (fill_value),
		.cmd         (cmd),
		.sts         (sts),
		.found       (found),
		.out_value   (out_value),
		.out_start   (out_start),
		.out_length  (out_length),
		.table_full  (table_full)
	);

endmodule
`default_nettype wire

@@ src/ivm_checker.sv @@
`default_nettype none
`include "interval_value_map_macros.svh"
module ivm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic found,
	input wire logic table_full
);

	`IVM_ASSERT_NOW(a_done_busy, done, busy)
	`IVM_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
	`IVM_ASSERT_NEXT(a_done_free, done, !busy)
	`IVM_ASSERT_NOW(a_flags_excl, done, !(found && table_full))

endmodule

bind interval_value_map ivm_checker u_ivm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.found      (found),
	.table_full (table_full)
);
`default_nettype wire

@@ dv/tb_interval_value_map.sv @@
`default_nettype none
module tb_interval_value_map;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = 16;
	localparam longint POS_TOP = 64'sd2147483647;
	localparam longint LEN_LIMIT = 64'sd4294967295;
	localparam int N_RANDOM = 1930;

	typedef struct {
		logic [2:0]  fn;
		logic [31:0] pos;
		logic [31:0] len;
		logic [31:0] val;
		bit          drain;
	} txn_t;

	typedef struct {
		logic        hit;
		logic [31:0] value;
		logic [31:0] lo;
		logic [31:0] length;
		logic        full;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] func = '0;
	logic signed [31:0] position = '0;
	logic [31:0] span_length = '0;
	logic signed [31:0] fill_value = '0;
	logic busy, done, found, table_full;
	logic signed [31:0] out_value, out_start;
	logic [31:0] out_length;

	interval_value_map dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .position(position), .span_length(span_length),
		.fill_value(fill_value), .done(done), .found(found),
		.out_value(out_value), .out_start(out_start), .out_length(out_length),
		.table_full(table_full)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// model of the stored step function
	longint map_lo[CAP];
	longint map_len[CAP];
	int     map_val[CAP];
	int     map_count = 0;
	longint pc_lo[CAP + 2];
	longint pc_hi[CAP + 2];
	int     pc_val[CAP + 2];
	int     pc_n;

	function automatic void add_piece(longint lo, longint hi, int v);
		if (pc_n < CAP + 2 && hi > lo) begin
			pc_lo[pc_n] = lo;
			pc_hi[pc_n] = hi;
			pc_val[pc_n] = v;
			pc_n++;
		end
	endfunction

	function automatic logic write_range(longint s, longint len, int v);
		longint e;
		int m;
		pc_n = 0;
		if (len == 0) return 1'b0;
		if (len - 1 > POS_TOP - s) len = POS_TOP - s + 1;
		e = s + len;
		for (int k = 0; k < map_count; k++)
			if (map_lo[k] < s)
				add_piece(map_lo[k], (map_lo[k] + map_len[k] < s) ?
					map_lo[k] + map_len[k] : s, map_val[k]);
		if (v != 0) add_piece(s, e, v);
		for (int k = 0; k < map_count; k++)
			if (map_lo[k] + map_len[k] > e)
				add_piece((map_lo[k] > e) ? map_lo[k] : e, map_lo[k] + map_len[k],
					map_val[k]);
		m = 0;
		for (int k = 0; k < pc_n; k++) begin
			if (m > 0 && pc_hi[m-1] == pc_lo[k] && pc_val[m-1] == pc_val[k] &&
					pc_hi[k] - pc_lo[m-1] <= LEN_LIMIT) begin
				pc_hi[m-1] = pc_hi[k];
			end else begin
				pc_lo[m] = pc_lo[k];
				pc_hi[m] = pc_hi[k];
				pc_val[m] = pc_val[k];
				m++;
			end
		end
		if (m > CAP) return 1'b1;
		for (int k = 0; k < m; k++) begin
			map_lo[k] = pc_lo[k];
			map_len[k] = pc_hi[k] - pc_lo[k];
			map_val[k] = pc_val[k];
		end
		map_count = m;
		return 1'b0;
	endfunction

	function automatic answer_t predict_map(txn_t t);
		answer_t a;
		longint p, hi;
		logic h;
		a = '{1'b0, '0, '0, '0, 1'b0};
		p = longint'(signed'(t.pos));
		if (t.fn == ivm_pkg::FUNC_ASSIGN) begin
			a.full = write_range(p, longint'(t.len), signed'(t.val));
			return a;
		end
		if (t.fn > ivm_pkg::FUNC_NEXT_NE) return a;
		for (int k = 0; k < map_count; k++) begin
			hi = map_lo[k] + map_len[k];
			case (t.fn)
				ivm_pkg::FUNC_LOOKUP:   h = map_lo[k] <= p && p < hi;
				ivm_pkg::FUNC_NEXT_ANY: h = p < hi;
				ivm_pkg::FUNC_NEXT_EQ:  h = p < hi && map_val[k] == signed'(t.val);
				default:                h = p < hi && map_val[k] != signed'(t.val);
			endcase
			if (h) begin
				a.hit = 1'b1;
				a.value = map_val[k];
				a.lo = map_lo[k][31:0];
				a.length = map_len[k][31:0];
				return a;
			end
		end
		return a;
	endfunction

	txn_t    pending[$];
	answer_t awaited[$];
	txn_t    cur;
	int      burst_left = 4;
	int      gap_left = 0;
	int      errors = 0;
	int      n_rejected = 0;
	int      n_hits = 0;
	int      n_results = 0;

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) awaited.push_back(predict_map(cur));
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending.size() > 0 &&
						(!pending[0].drain || awaited.size() == 0)) begin
					cur = pending.pop_front();
					func <= cur.fn;
					position <= cur.pos;
					span_length <= cur.len;
					fill_value <= cur.val;
					start <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		answer_t x;
		if (arst_n && done) begin
			n_results++;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result transaction");
			end else begin
				x = awaited.pop_front();
				if (table_full) n_rejected++;
				if (found) n_hits++;
				if (found !== x.hit || out_value !== x.value || out_start !== x.lo ||
						out_length !== x.length || table_full !== x.full) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch: exp f=%0b v=%0d s=%0d l=%0d full=%0b",
							x.hit, signed'(x.value), signed'(x.lo), x.length, x.full);
						$display("          got f=%0b v=%0d s=%0d l=%0d full=%0b",
							found, out_value, out_start, out_length, table_full);
					end
				end
			end
		end
	end

	function automatic txn_t mk(logic [2:0] fn, logic [31:0] pos, logic [31:0] len,
			logic [31:0] val);
		txn_t t;
		t.fn = fn;
		t.pos = pos;
		t.len = len;
		t.val = val;
		t.drain = 1'b0;
		return t;
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'd1;
			1: return 32'd2;
			2: return 32'hFFFF_FFFF;
			3: return 32'd0;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		txn_t t;
		logic [31:0] base;
		pending.push_back(mk(ivm_pkg::FUNC_LOOKUP, 32'd0, 32'd0, 32'd0));
		pending.push_back(mk(ivm_pkg::FUNC_NEXT_ANY, 32'h8000_0000, 32'd0, 32'd0));
		pending.push_back(mk(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		pending.push_back(mk(3'd6, 32'd0, 32'd1, 32'd1));
		pending.push_back(mk(3'd7, 32'd5, 32'd5, 32'd5));
		pending.push_back(mk(ivm_pkg::FUNC_ASSIGN, 32'd100, 32'd0, 32'd9));
		pending.push_back(mk(ivm_pkg::FUNC_ASSIGN, 32'h8000_0000, 32'hFFFF_FFFF, 32'd5));
		pending.push_back(mk(ivm_pkg::FUNC_ASSIGN, 32'h7FFF_FFFF, 32'd1, 32'd5));
		pending.push_back(mk(ivm_pkg::FUNC_LOOKUP, 32'h7FFF_FFFF, 32'd0, 32'd0));
		pending.push_back(mk(ivm_pkg::FUNC_NEXT_ANY, 32'h8000_0000, 32'd0, 32'd0));
		pending.push_back(mk(ivm_pkg::FUNC_NEXT_EQ, 32'd0, 32'd0, 32'd5));
		pending.push_back(mk(ivm_pkg::FUNC_NEXT_NE, 32'd0, 32'd0, 32'd5));
		pending.push_back(mk(ivm_pkg::FUNC_NEXT_EQ, 32'd0, 32'd0, 32'd0));
		pending.push_back(mk(ivm_pkg::FUNC_ASSIGN, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0));
		pending.push_back(mk(ivm_pkg::FUNC_ASSIGN, 32'h7FFF_FFF0, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		pending.push_back(mk(ivm_pkg::FUNC_LOOKUP, 32'h7FFF_FFFF, 32'd0, 32'd0));
		pending.push_back(mk(ivm_pkg::FUNC_ASSIGN, 32'd0, 32'd10, 32'h7FFF_FFFF));
		pending.push_back(mk(ivm_pkg::FUNC_ASSIGN, 32'd10, 32'd10, 32'h7FFF_FFFF));
		pending.push_back(mk(ivm_pkg::FUNC_ASSIGN, 32'd5, 32'd3, 32'h8000_0000));
		pending.push_back(mk(ivm_pkg::FUNC_NEXT_ANY, 32'hFFFF_FFFF, 32'd0, 32'd0));
		pending.push_back(mk(ivm_pkg::FUNC_NEXT_NE, 32'd6, 32'd0, 32'h8000_0000));
		pending.push_back(mk(ivm_pkg::FUNC_LOOKUP, 32'd20, 32'd0, 32'd0));
		base = 32'd0;
		for (int i = 0; i < N_RANDOM; i++) begin
			if ($urandom_range(0, 60) == 0) base = $urandom;
			case ($urandom_range(0, 19))
				0: t = mk(ivm_pkg::FUNC_ASSIGN, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0);
				1: t = mk(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom);
				2, 3, 4, 5, 6, 7, 8, 9, 10:
					t = mk(ivm_pkg::FUNC_ASSIGN, base + $urandom_range(0, 63),
						($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 12),
						pick_value());
				default:
					t = mk(3'($urandom_range(1, 4)), base + $urandom_range(0, 70) - 4,
						$urandom, pick_value());
			endcase
			t.drain = ($urandom_range(0, 150) == 0) || i == N_RANDOM / 2;
			pending.push_back(t);
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		while (pending.size() != 0 || start || awaited.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("ran %0d transactions: %0d search/lookup hits,", n_results, n_hits);
		$display("%0d assigns rejected as full", n_rejected);
		if (errors == 0 && awaited.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, awaited.size());
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout");
		$display("FAILED: results differ");
		$finish;
	end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+src
src/ivm_pkg.sv
src/ivm_ctrl.sv
src/ivm_dpath.sv
src/interval_value_map.sv
src/ivm_checker.sv
dv/tb_interval_value_map.sv
